// File: rtl/core/awf_pkg.sv
// awf_pkg: shared widths, register indexes, reset values and sequencer states
// for the adaptive weight filter unit; no dependencies
package awf_pkg;

    // sample and result widths
    localparam int SAMPLE_BITS = 24;
    localparam int ZERO_BITS   = 24;
    localparam int OUT_BITS    = 25;
    localparam int SUB_BITS    = ((SAMPLE_BITS > ZERO_BITS) ? SAMPLE_BITS : ZERO_BITS) + 1;
    localparam int DELTA_BITS  = OUT_BITS + 1;
    localparam int CREDIT_BITS = 8;

    // shared radix-4 divider
    localparam int DIV_BITS   = DELTA_BITS;
    localparam int DEN_BITS   = 16;
    localparam int DIV_STEPS  = DIV_BITS / 2;
    localparam int STEP_BITS  = $clog2(DIV_STEPS);
    localparam int EXT_BITS   = DIV_BITS + 1;
    localparam int SUM_BITS   = EXT_BITS + 1;

    // gain product
    localparam int GAIN_BITS  = 32;
    localparam int PROD_BITS  = OUT_BITS + GAIN_BITS + 1;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ZERO_OFFSET    = 3'd0,
        CFG_CREDIT_LIMIT   = 3'd1,
        CFG_CREDIT_DIVISOR = 3'd2,
        CFG_NOISE_BAND     = 3'd3,
        CFG_SCALAR_BASE    = 3'd4,
        CFG_DAMPING_OFFSET = 3'd5,
        CFG_GAIN           = 3'd6
    } cfg_index_t;

    // register reset values
    localparam logic [23:0] RST_ZERO_OFFSET    = 24'd0;
    localparam logic [6:0]  RST_CREDIT_LIMIT   = 7'd10;
    localparam logic [7:0]  RST_CREDIT_DIVISOR = 8'd2;
    localparam logic [15:0] RST_NOISE_BAND     = 16'd2000;
    localparam logic [7:0]  RST_SCALAR_BASE    = 8'd8;
    localparam logic [7:0]  RST_DAMPING_OFFSET = 8'd1;
    localparam logic [31:0] RST_GAIN           = 32'd1880774;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELTA,
        ST_DIVX_LOAD,
        ST_DIVX_RUN,
        ST_CREDIT,
        ST_CREDIT_SUM,
        ST_SCALAR,
        ST_DIVS_LOAD,
        ST_DIVS_RUN,
        ST_FILTER,
        ST_WEIGHT,
        ST_OUTPUT
    } state_t;

endpackage

// File: rtl/core/adaptive_weight_filter_unit.sv
// adaptive_weight_filter_unit: zero offset, credit-driven adaptive smoothing
// and gain scaling of load-cell samples; depends on awf_pkg
// a request passes the delta, divider, credit, scalar, divider, filter, weight and
//   output states; a new request is taken only once the last one is done, and the
//   shared radix-4 divider (13 steps each pass) serves both passes
// a finished result waits in the output register while the next request runs
// reset (rst_n low, asynchronous): registers return to defaults, credit and
//   the kept filtered value clear to zero, no result pending
module adaptive_weight_filter_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_we,
    input  logic [awf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [awf_pkg::CFG_DATA_BITS-1:0]     cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [awf_pkg::SAMPLE_BITS-1:0] raw_count,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [awf_pkg::OUT_BITS-1:0]   net_count,
    output logic signed [awf_pkg::OUT_BITS-1:0]   filtered_count,
    output logic signed [awf_pkg::OUT_BITS-1:0]   weight_steps,
    output logic signed [awf_pkg::CREDIT_BITS-1:0] credit_now
);

    // configuration registers
    logic [23:0] zero_offset_reg;
    logic [6:0]  credit_limit_reg;
    logic [7:0]  credit_divisor_reg;
    logic [15:0] noise_band_reg;
    logic [7:0]  scalar_base_reg;
    logic [7:0]  damping_offset_reg;
    logic [31:0] gain_reg;

    // sequencer
    awf_pkg::state_t state_reg, state_next;
    logic            in_accept;
    logic            out_load;
    logic            div_load_x;
    logic            div_load_s;
    logic            div_run;
    logic            div_last;

    // working registers
    logic signed [awf_pkg::OUT_BITS-1:0]    net_reg;
    logic signed [awf_pkg::DELTA_BITS-1:0]  delta_reg;
    logic [awf_pkg::DIV_BITS-1:0]           abs_delta_reg;
    logic signed [awf_pkg::EXT_BITS-1:0]    extra_reg;
    logic                                   clear_reg;
    logic [7:0]                             scalar_reg;
    logic signed [awf_pkg::OUT_BITS-1:0]    prev_reg;
    logic signed [awf_pkg::CREDIT_BITS-1:0] credit_reg;
    logic signed [awf_pkg::OUT_BITS-1:0]    weight_reg;

    // divider registers
    logic [awf_pkg::DEN_BITS-1:0]  div_rem_reg;
    logic [awf_pkg::DIV_BITS-1:0]  div_quo_reg;
    logic [awf_pkg::DEN_BITS-1:0]  div_den_reg;
    logic [awf_pkg::STEP_BITS-1:0] div_cnt_reg;

    // output register
    logic                                   out_valid_reg;
    logic signed [awf_pkg::OUT_BITS-1:0]    out_net_reg;
    logic signed [awf_pkg::OUT_BITS-1:0]    out_filt_reg;
    logic signed [awf_pkg::OUT_BITS-1:0]    out_weight_reg;
    logic signed [awf_pkg::CREDIT_BITS-1:0] out_credit_reg;

    // combinational datapath
    logic signed [awf_pkg::SUB_BITS-1:0]    net_full;
    logic signed [awf_pkg::DELTA_BITS-1:0]  delta_next;
    logic [awf_pkg::DIV_BITS-1:0]           abs_delta_next;
    logic                                   delta_neg;
    logic                                   delta_zero;
    logic signed [awf_pkg::EXT_BITS-1:0]    quo_signed;
    logic [awf_pkg::CREDIT_BITS:0]          abs_credit;
    logic                                   credit_earns;
    logic                                   credit_clear;
    logic signed [awf_pkg::SUM_BITS-1:0]    credit_sum;
    logic signed [awf_pkg::SUM_BITS-1:0]    sign_term;
    logic signed [awf_pkg::CREDIT_BITS-1:0] credit_sat;
    logic [7:0]                             scalar_next;
    logic [15:0]                            scalar_sq;
    logic [16:0]                            smooth_den_full;
    logic [awf_pkg::DEN_BITS-1:0]           smooth_den;
    logic [awf_pkg::DEN_BITS-1:0]           credit_den;
    logic signed [awf_pkg::EXT_BITS-1:0]    filt_sum;
    logic signed [awf_pkg::PROD_BITS-1:0]   gain_prod;

    // divider step signals
    logic [awf_pkg::DEN_BITS+1:0] div_shifted;
    logic [awf_pkg::DEN_BITS+1:0] div_d1;
    logic [awf_pkg::DEN_BITS+1:0] div_d2;
    logic [awf_pkg::DEN_BITS+1:0] div_d3;
    logic [awf_pkg::DEN_BITS+1:0] div_rem_full;
    logic [1:0]                   div_digit;

    assign in_stall  = (state_reg != awf_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    assign net_count      = out_net_reg;
    assign filtered_count = out_filt_reg;
    assign weight_steps   = out_weight_reg;
    assign credit_now     = out_credit_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_offset_reg    <= awf_pkg::RST_ZERO_OFFSET;
            credit_limit_reg   <= awf_pkg::RST_CREDIT_LIMIT;
            credit_divisor_reg <= awf_pkg::RST_CREDIT_DIVISOR;
            noise_band_reg     <= awf_pkg::RST_NOISE_BAND;
            scalar_base_reg    <= awf_pkg::RST_SCALAR_BASE;
            damping_offset_reg <= awf_pkg::RST_DAMPING_OFFSET;
            gain_reg           <= awf_pkg::RST_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                awf_pkg::CFG_ZERO_OFFSET:    zero_offset_reg    <= cfg_data[23:0];
                awf_pkg::CFG_CREDIT_LIMIT:   credit_limit_reg   <= cfg_data[6:0];
                awf_pkg::CFG_CREDIT_DIVISOR: credit_divisor_reg <= cfg_data[7:0];
                awf_pkg::CFG_NOISE_BAND:     noise_band_reg     <= cfg_data[15:0];
                awf_pkg::CFG_SCALAR_BASE:    scalar_base_reg    <= cfg_data[7:0];
                awf_pkg::CFG_DAMPING_OFFSET: damping_offset_reg <= cfg_data[7:0];
                awf_pkg::CFG_GAIN:           gain_reg           <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= awf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and sequencer controls
    always_comb
    begin
        state_next = state_reg;
        div_load_x = 1'b0;
        div_load_s = 1'b0;
        div_run    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            awf_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = awf_pkg::ST_DELTA;
                end
            end
            awf_pkg::ST_DELTA:
            begin
                state_next = awf_pkg::ST_DIVX_LOAD;
            end
            awf_pkg::ST_DIVX_LOAD:
            begin
                div_load_x = 1'b1;
                state_next = awf_pkg::ST_DIVX_RUN;
            end
            awf_pkg::ST_DIVX_RUN:
            begin
                div_run = 1'b1;
                if (div_last)
                begin
                    state_next = awf_pkg::ST_CREDIT;
                end
            end
            awf_pkg::ST_CREDIT:
            begin
                state_next = awf_pkg::ST_CREDIT_SUM;
            end
            awf_pkg::ST_CREDIT_SUM:
            begin
                state_next = awf_pkg::ST_SCALAR;
            end
            awf_pkg::ST_SCALAR:
            begin
                state_next = awf_pkg::ST_DIVS_LOAD;
            end
            awf_pkg::ST_DIVS_LOAD:
            begin
                div_load_s = 1'b1;
                state_next = awf_pkg::ST_DIVS_RUN;
            end
            awf_pkg::ST_DIVS_RUN:
            begin
                div_run = 1'b1;
                if (div_last)
                begin
                    state_next = awf_pkg::ST_FILTER;
                end
            end
            awf_pkg::ST_FILTER:
            begin
                state_next = awf_pkg::ST_WEIGHT;
            end
            awf_pkg::ST_WEIGHT:
            begin
                state_next = awf_pkg::ST_OUTPUT;
            end
            awf_pkg::ST_OUTPUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = awf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = awf_pkg::ST_IDLE;
            end
        endcase
    end

    // net count and change against the kept filtered value
    assign net_full   = awf_pkg::SUB_BITS'(raw_count)
                      - awf_pkg::SUB_BITS'($signed(zero_offset_reg));
    assign delta_next = awf_pkg::DELTA_BITS'(net_reg) - awf_pkg::DELTA_BITS'(prev_reg);
    assign abs_delta_next = delta_reg[awf_pkg::DELTA_BITS-1]
                          ? awf_pkg::DIV_BITS'(-delta_reg)
                          : awf_pkg::DIV_BITS'(delta_reg);
    assign delta_neg  = delta_reg[awf_pkg::DELTA_BITS-1];
    assign delta_zero = (delta_reg == '0);

    // quotient with the sign of the change
    assign quo_signed = delta_neg ? -$signed({1'b0, div_quo_reg})
                                  :  $signed({1'b0, div_quo_reg});

    // credit rules
    assign abs_credit = credit_reg[awf_pkg::CREDIT_BITS-1]
                      ? (awf_pkg::CREDIT_BITS+1)'(-$signed({credit_reg[awf_pkg::CREDIT_BITS-1],
                                                              credit_reg}))
                      : {1'b0, credit_reg};
    assign credit_earns = (abs_credit <= (awf_pkg::CREDIT_BITS+1)'(credit_limit_reg));
    assign credit_clear = (!delta_neg && credit_reg[awf_pkg::CREDIT_BITS-1])
                       || ((delta_neg || delta_zero) && !credit_reg[awf_pkg::CREDIT_BITS-1]
                           && (credit_reg != '0))
                       || (abs_delta_reg < awf_pkg::DIV_BITS'(noise_band_reg));

    // credit sum with saturation to the signed credit range
    assign sign_term  = delta_neg  ? -awf_pkg::SUM_BITS'(1)
                      : delta_zero ?  awf_pkg::SUM_BITS'(0)
                                   :  awf_pkg::SUM_BITS'(1);
    assign credit_sum = awf_pkg::SUM_BITS'(credit_reg) + awf_pkg::SUM_BITS'(extra_reg)
                      + sign_term;
    always_comb
    begin
        if (credit_sum[awf_pkg::SUM_BITS-1:awf_pkg::CREDIT_BITS-1] == '0
            || credit_sum[awf_pkg::SUM_BITS-1:awf_pkg::CREDIT_BITS-1] == '1)
        begin
            credit_sat = credit_sum[awf_pkg::CREDIT_BITS-1:0];
        end
        else if (credit_sum[awf_pkg::SUM_BITS-1])
        begin
            credit_sat = {1'b1, {(awf_pkg::CREDIT_BITS-1){1'b0}}};
        end
        else
        begin
            credit_sat = {1'b0, {(awf_pkg::CREDIT_BITS-1){1'b1}}};
        end
    end

    // smoothing scalar and divisor
    assign scalar_next = (abs_credit > {1'b0, scalar_base_reg})
                       ? 8'd0
                       : 8'({1'b0, scalar_base_reg} - abs_credit);
    assign scalar_sq       = 16'(scalar_reg) * 16'(scalar_reg);
    assign smooth_den_full = 17'(scalar_sq) + 17'(damping_offset_reg);
    assign smooth_den      = (smooth_den_full == '0) ? awf_pkg::DEN_BITS'(1)
                                                     : awf_pkg::DEN_BITS'(smooth_den_full);
    assign credit_den      = (credit_divisor_reg == '0) ? awf_pkg::DEN_BITS'(1)
                                                        : awf_pkg::DEN_BITS'(credit_divisor_reg);

    // filtered update and gain product
    assign filt_sum  = awf_pkg::EXT_BITS'(prev_reg) + quo_signed;
    assign gain_prod = awf_pkg::PROD_BITS'(prev_reg)
                     * awf_pkg::PROD_BITS'($signed({1'b0, gain_reg}));

    // radix-4 restoring divider step: two quotient bits per cycle
    assign div_shifted = {div_rem_reg, div_quo_reg[awf_pkg::DIV_BITS-1 -: 2]};
    assign div_d1      = {2'b00, div_den_reg};
    assign div_d2      = {1'b0, div_den_reg, 1'b0};
    assign div_d3      = div_d1 + div_d2;
    always_comb
    begin
        if (div_shifted >= div_d3)
        begin
            div_digit    = 2'd3;
            div_rem_full = div_shifted - div_d3;
        end
        else if (div_shifted >= div_d2)
        begin
            div_digit    = 2'd2;
            div_rem_full = div_shifted - div_d2;
        end
        else if (div_shifted >= div_d1)
        begin
            div_digit    = 2'd1;
            div_rem_full = div_shifted - div_d1;
        end
        else
        begin
            div_digit    = 2'd0;
            div_rem_full = div_shifted;
        end
    end
    assign div_last = (div_cnt_reg == awf_pkg::STEP_BITS'(awf_pkg::DIV_STEPS - 1));

    // shared divider registers
    always_ff @(posedge clk)
    begin
        if (div_load_x || div_load_s)
        begin
            div_rem_reg <= '0;
            div_cnt_reg <= '0;
            div_quo_reg <= div_load_x ? abs_delta_next : abs_delta_reg;
            div_den_reg <= div_load_x ? credit_den : smooth_den;
        end
        else if (div_run)
        begin
            div_rem_reg <= div_rem_full[awf_pkg::DEN_BITS-1:0];
            div_quo_reg <= {div_quo_reg[awf_pkg::DIV_BITS-3:0], div_digit};
            div_cnt_reg <= div_cnt_reg + awf_pkg::STEP_BITS'(1);
        end
    end

    // working datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            net_reg <= net_full[awf_pkg::OUT_BITS-1:0];
        end
        if (state_reg == awf_pkg::ST_DELTA)
        begin
            delta_reg <= delta_next;
        end
        if (div_load_x)
        begin
            abs_delta_reg <= abs_delta_next;
        end
        if (state_reg == awf_pkg::ST_CREDIT)
        begin
            extra_reg <= credit_earns ? quo_signed : '0;
            clear_reg <= credit_clear;
        end
        if (state_reg == awf_pkg::ST_SCALAR)
        begin
            scalar_reg <= scalar_next;
        end
        if (state_reg == awf_pkg::ST_WEIGHT)
        begin
            weight_reg <= gain_prod[awf_pkg::OUT_BITS+awf_pkg::GAIN_BITS-1:awf_pkg::GAIN_BITS];
        end
    end

    // kept filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            prev_reg   <= '0;
        end
        else
        begin
            if (state_reg == awf_pkg::ST_CREDIT_SUM)
            begin
                credit_reg <= clear_reg ? '0 : credit_sat;
            end
            if (state_reg == awf_pkg::ST_FILTER)
            begin
                prev_reg <= filt_sum[awf_pkg::OUT_BITS-1:0];
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_net_reg    <= net_reg;
            out_filt_reg   <= prev_reg;
            out_weight_reg <= weight_reg;
            out_credit_reg <= credit_reg;
        end
    end

    // a new request always starts with the change computation
    assert_accept_to_delta: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == awf_pkg::ST_DELTA)
        else $error("accepted request did not start the sequence");

    // a result only appears from the output step
    assert_valid_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == awf_pkg::ST_OUTPUT))
        else $error("result valid raised outside the output step");

    // a waiting result is never overwritten
    assert_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !out_load)
        else $error("pending result overwritten");

    // the divider never runs against a zero divisor
    assert_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == awf_pkg::ST_DIVX_RUN || state_reg == awf_pkg::ST_DIVS_RUN)
        |-> div_den_reg != '0)
        else $error("divider running with zero divisor");

endmodule

// File: verif/adaptive_weight_filter_unit_tb.sv
// adaptive_weight_filter_unit_tb: self-checking bench for the adaptive weight filter unit
// drives converter samples and register writes, predicts every result in a checker class
// depends on awf_pkg and the adaptive_weight_filter_unit rtl
`timescale 1ns / 100ps

module adaptive_weight_filter_unit_tb;

    import awf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic signed [OUT_BITS-1:0]    net;
        logic signed [OUT_BITS-1:0]    filtered;
        logic signed [OUT_BITS-1:0]    weight;
        logic signed [CREDIT_BITS-1:0] credit;
    } weigh_result_t;

    // predicts weighing results and compares them against the unit
    class weigh_checker;
        logic signed [23:0] zero_offset;
        logic [6:0]         credit_limit;
        logic [7:0]         credit_divisor;
        logic [15:0]        noise_band;
        logic [7:0]         scalar_base;
        logic [7:0]         damping_offset;
        logic [31:0]        gain;

        longint        kept_filtered;
        int            credit;
        weigh_result_t pending_weights[$];
        int            mismatches;
        int            samples;
        int            weighed;
        int            credit_low;
        int            credit_high;

        function new();
            zero_offset    = RST_ZERO_OFFSET;
            credit_limit   = RST_CREDIT_LIMIT;
            credit_divisor = RST_CREDIT_DIVISOR;
            noise_band     = RST_NOISE_BAND;
            scalar_base    = RST_SCALAR_BASE;
            damping_offset = RST_DAMPING_OFFSET;
            gain           = RST_GAIN;
            kept_filtered  = 0;
            credit         = 0;
            mismatches     = 0;
            samples        = 0;
            weighed        = 0;
            credit_low     = 0;
            credit_high    = 0;
        endfunction

        // mirror of a register write, unused index leaves everything alone
        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_ZERO_OFFSET:    zero_offset    = data[23:0];
                CFG_CREDIT_LIMIT:   credit_limit   = data[6:0];
                CFG_CREDIT_DIVISOR: credit_divisor = data[7:0];
                CFG_NOISE_BAND:     noise_band     = data[15:0];
                CFG_SCALAR_BASE:    scalar_base    = data[7:0];
                CFG_DAMPING_OFFSET: damping_offset = data[7:0];
                CFG_GAIN:           gain           = data[31:0];
                default: ;
            endcase
        endfunction

        function longint wrap_out(longint v);
            logic signed [OUT_BITS-1:0] t;
            t = v[OUT_BITS-1:0];
            return t;
        endfunction

        // one filter step: net count, credit update, smoothing and gain
        function weigh_result_t smooth_sample(logic signed [SAMPLE_BITS-1:0] raw);
            longint          raw_l, net, delta, delta_mag, extra, cdiv;
            longint          scalar, divisor, filtered, weight, next_credit;
            longint unsigned mag, gmul, prod;
            int              credit_mag;
            weigh_result_t   r;
            raw_l = raw;
            net   = wrap_out(raw_l - longint'(zero_offset));
            delta = net - kept_filtered;
            delta_mag  = (delta < 0) ? -delta : delta;
            credit_mag = (credit < 0) ? -credit : credit;

            // extra credit only while credit is still small
            cdiv  = (credit_divisor == 0) ? 1 : longint'(credit_divisor);
            extra = 0;
            if (credit_mag <= int'(credit_limit))
                extra = delta / cdiv;

            // reversal or small change clears credit, else accumulate and saturate
            if ((delta >= 0 && credit < 0) || (delta <= 0 && credit > 0) ||
                delta_mag < longint'(noise_band))
            begin
                credit = 0;
            end
            else
            begin
                next_credit = credit + extra + ((delta > 0) ? 1 : ((delta < 0) ? -1 : 0));
                if (next_credit > 127)
                    next_credit = 127;
                if (next_credit < -128)
                    next_credit = -128;
                credit = int'(next_credit);
            end
            credit_mag = (credit < 0) ? -credit : credit;

            // smoothing divisor shrinks as credit builds
            scalar = longint'(scalar_base) - credit_mag;
            if (scalar < 0)
                scalar = 0;
            divisor = scalar * scalar + longint'(damping_offset);
            if (divisor == 0)
                divisor = 1;
            filtered      = wrap_out(kept_filtered + delta / divisor);
            kept_filtered = filtered;

            // q0.32 gain, floored toward minus infinity
            mag  = (filtered < 0) ? -filtered : filtered;
            gmul = gain;
            prod = mag * gmul;
            if (filtered >= 0)
                weight = longint'(prod >> 32);
            else
                weight = -longint'((prod + 64'hFFFF_FFFF) >> 32);

            r.net      = net[OUT_BITS-1:0];
            r.filtered = filtered[OUT_BITS-1:0];
            r.weight   = weight[OUT_BITS-1:0];
            r.credit   = credit[CREDIT_BITS-1:0];
            return r;
        endfunction

        function void take_sample(logic signed [SAMPLE_BITS-1:0] raw);
            pending_weights.push_back(smooth_sample(raw));
            samples++;
        endfunction

        function bit field_ok(string label, longint want, longint got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
                return 0;
            end
            return 1;
        endfunction

        function void check_weight(weigh_result_t got);
            weigh_result_t want;
            bit            ok;
            if (pending_weights.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual net %0d filtered %0d",
                         $time, got.net, got.filtered);
                mismatches++;
                return;
            end
            want = pending_weights.pop_front();
            weighed++;
            ok = field_ok("net_count", want.net, got.net) &
                 field_ok("filtered_count", want.filtered, got.filtered) &
                 field_ok("weight_steps", want.weight, got.weight) &
                 field_ok("credit_now", want.credit, got.credit);
            if (!ok)
                mismatches++;
            if (int'(want.credit) < credit_low)
                credit_low = want.credit;
            if (int'(want.credit) > credit_high)
                credit_high = want.credit;
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [CFG_INDEX_BITS-1:0]       cfg_index;
    logic [CFG_DATA_BITS-1:0]        cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic signed [SAMPLE_BITS-1:0]   raw_count;
    logic                            out_valid;
    logic                            out_stall;
    logic signed [OUT_BITS-1:0]      net_count;
    logic signed [OUT_BITS-1:0]      filtered_count;
    logic signed [OUT_BITS-1:0]      weight_steps;
    logic signed [CREDIT_BITS-1:0]   credit_now;

    weigh_checker chk;
    bit           no_idling;
    int           stall_budget;
    int           stuck_cycles;
    int           settings_used;

    adaptive_weight_filter_unit dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .raw_count      (raw_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .net_count      (net_count),
        .filtered_count (filtered_count),
        .weight_steps   (weight_steps),
        .credit_now     (credit_now)
    );

    // clock
    always #4 clk = ~clk;

    function automatic int idle_draw();
        return no_idling ? 0 : $urandom_range(0, 7);
    endfunction

    // accepted sample requests feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            chk.take_sample(raw_count);
    end

    // accepted results are checked, then a new stall count is drawn
    always @(posedge clk)
    begin
        weigh_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.net      = net_count;
            got.filtered = filtered_count;
            got.weight   = weight_steps;
            got.credit   = credit_now;
            chk.check_weight(got);
            stall_budget = idle_draw();
        end
    end

    // stall only while a result is waiting
    always @(negedge clk)
    begin
        if (rst_n && out_valid && stall_budget > 0)
        begin
            out_stall <= 1'b1;
            stall_budget--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any request moving
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one sample request, called and returning at a falling edge
    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] raw);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        raw_count <= raw;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (chk.pending_weights.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        chk.set_reg(idx, data);
        @(negedge clk);
    endtask

    // random bits above the register width
    function automatic logic [31:0] with_junk(logic [31:0] value, int width);
        logic [31:0] mask;
        mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
        return (value & mask) | ($urandom & ~mask);
    endfunction

    task automatic apply_setting(int zero, int climit, int cdiv, int band,
                                 int sbase, int doff, logic [31:0] g);
        write_reg(CFG_SPARE, $urandom);
        write_reg(CFG_ZERO_OFFSET, with_junk(zero, 24));
        write_reg(CFG_CREDIT_LIMIT, with_junk(climit, 7));
        write_reg(CFG_CREDIT_DIVISOR, with_junk(cdiv, 8));
        write_reg(CFG_NOISE_BAND, with_junk(band, 16));
        write_reg(CFG_SCALAR_BASE, with_junk(sbase, 8));
        write_reg(CFG_DAMPING_OFFSET, with_junk(doff, 8));
        write_reg(CFG_GAIN, g);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // load-cell style traffic: ramps, holds, jitter, jumps and stray noise
    task automatic weigh_walk(int n);
        int                            level;
        int                            seg_left;
        int                            kind;
        int                            step;
        logic signed [SAMPLE_BITS-1:0] sample;
        level    = int'($urandom_range(0, 2000000)) - 1000000;
        seg_left = 0;
        kind     = 0;
        step     = 0;
        for (int i = 0; i < n; i++)
        begin
            if (seg_left == 0)
            begin
                kind     = $urandom_range(0, 9);
                seg_left = $urandom_range(3, 20);
                step     = int'($urandom_range(1, 1 << $urandom_range(4, 20)));
                if ($urandom_range(0, 1))
                    step = -step;
            end
            seg_left--;
            if (kind <= 4)
                level += step;
            else if (kind <= 6)
                level += int'($urandom_range(0, 64)) - 32;
            else if (kind == 7)
                level = int'($urandom_range(0, 24'hFF_FFFF)) - 8388608;
            else if (kind == 9)
                level += int'($urandom_range(0, 4000)) - 2000;
            if (level > 8388607)
                level = 8388607;
            if (level < -8388608)
                level = -8388608;
            sample = (kind == 8) ? SAMPLE_BITS'($urandom) : level[SAMPLE_BITS-1:0];
            send_sample(sample);
        end
    endtask

    task automatic random_phase(bit steady, int n);
        no_idling = steady;
        weigh_walk(n);
        drain_results();
    endtask

    // main sequence
    initial
    begin
        int directed_counts[21];
        directed_counts = '{0, 8388607, 8388607, -8388608, -8388608, 1, -1, 0,
                            300000, 600000, 900000, 1200000, 1500000, 1500100,
                            1499900, 1000000, 500000, 0, -500000, -1000000, 5};
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        raw_count     = '0;
        out_stall     = 1'b0;
        no_idling     = 1'b0;
        stall_budget  = 0;
        stuck_cycles  = 0;
        settings_used = 1;
        chk = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, credit build-up, saturation, reversals, holds
        foreach (directed_counts[k])
            send_sample(directed_counts[k][SAMPLE_BITS-1:0]);
        drain_results();

        // default-like setting, all registers written
        apply_setting(0, 10, 2, 2000, 8, 1, 32'd1880774);
        random_phase(1'b0, 150);

        // upper extremes
        apply_setting(8388607, 127, 255, 65535, 255, 255, 32'hFFFF_FFFF);
        random_phase(1'b1, 150);

        // lower extremes: zero credit divisor and zero smoothing divisor
        apply_setting(-8388608, 0, 0, 0, 0, 0, 32'h0);
        random_phase(1'b0, 150);

        // small base so credit drives the scalar negative
        apply_setting(12345, 127, 1, 0, 3, 0, 32'h8000_0000);
        random_phase(1'b0, 150);

        // random settings
        for (int p = 0; p < 3; p++)
        begin
            apply_setting($urandom, $urandom_range(0, 127), $urandom_range(0, 255),
                          $urandom_range(0, 1 << $urandom_range(4, 16)),
                          $urandom_range(0, 40), $urandom_range(0, 255), $urandom);
            random_phase(p == 1, 130);
        end

        // let any stray result show up
        while (chk.pending_weights.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d samples weighed under %0d register settings, %0d results compared",
                 chk.samples, settings_used, chk.weighed);
        $display("credit spanned %0d to %0d, %0d results disagreed",
                 chk.credit_low, chk.credit_high, chk.mismatches);
        if (chk.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/awf_pkg.sv
rtl/core/adaptive_weight_filter_unit.sv
verif/adaptive_weight_filter_unit_tb.sv
